@@ sv/mlf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlf_pkg
// Shared types and constants of the multichannel linear fader.
// ----------------------------------------------------------------------------
package mlf_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int MAX_RESULTS  = 20;
   localparam int RES_W        = $clog2(MAX_RESULTS + 1);
   localparam int ACTIVE_W     = 5;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_SETUP = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_STOP  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      WR_SETUP,
      WR_LEVEL,
      WR_TARGET
   } wr_sel_type;

   localparam logic KIND_LEVEL    = 1'b0;
   localparam logic KIND_EVENT    = 1'b1;
   localparam logic EVT_CHANGED   = 1'b0;
   localparam logic EVT_FINISHED  = 1'b1;
   localparam logic MODE_REST     = 1'b0;
   localparam logic MODE_FADE     = 1'b1;

   typedef struct packed {
      logic [15:0] cur;
      logic [15:0] src;
      logic [15:0] tgt;
      logic [15:0] mag;
      logic        neg;
   } row_type;

   typedef struct packed {
      logic       latch_item;
      logic       load_fade;
      logic       calc_elapsed;
      logic       rd_en;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       mul;
      logic       div_start;
      logic       div_step;
      logic       out_load;
      logic       out_kind;
      logic       out_code;
      logic       out_state;
      logic       out_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic lt;
      logic div_last;
      logic changed;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

@@ sv/mlf_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlf_req_if / mlf_rsp_if
// Valid/ready channels for fader requests and fader results.
// ----------------------------------------------------------------------------
interface mlf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  channel;
   logic [15:0] target_value;
   logic [15:0] source_value;
   logic        use_source;
   logic [31:0] duration_ms;
   logic [31:0] now_ms;

   modport source (output valid, opcode, channel, target_value, source_value,
                   use_source, duration_ms, now_ms, input ready);
   modport sink (input valid, opcode, channel, target_value, source_value,
                 use_source, duration_ms, now_ms, output ready);
endinterface

interface mlf_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  out_channel;
   logic [15:0] level;
   logic        event_code;
   logic        fade_state;
   logic        last;

   modport source (output valid, kind, out_channel, level, event_code,
                   fade_state, last, input ready);
   modport sink (input valid, kind, out_channel, level, event_code,
                 fade_state, last, output ready);
endinterface
`default_nettype wire

@@ sv/multichannel_linear_fader.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_linear_fader
// Linear fades of up to CHANNELS levels over a common fade length.
// ----------------------------------------------------------------------------
// One request at a time. A start or tick that fades walks the active
// channels one by one through the single multiplier and the bit-serial
// divider (read, multiply, divider load, 16 quotient steps, write back).
// A fade completion rewrites each channel to its target (read, then write)
// before reporting. Results are delivered through a one-entry output
// register, at most 20 per request.
// ----------------------------------------------------------------------------
module multichannel_linear_fader #(
   parameter int CHANNELS = mlf_pkg::CHANNELS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   mlf_req_if.sink                       req_ch,
   mlf_rsp_if.source                     rsp_ch,
   input  wire                           csr_write_enable,
   input  wire  [mlf_pkg::ACTIVE_W-1:0]  csr_write_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   mlf_pkg::ctl_cmd_type   cmd;
   mlf_pkg::dp_status_type sts;
   logic [CH_W-1:0]        addr;

   mlf_controller #(.CHANNELS(CHANNELS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_opcode       (req_ch.opcode),
      .req_channel      (req_ch.channel),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .sts              (sts),
      .cmd              (cmd),
      .addr             (addr)
   );

   mlf_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .addr             (addr),
      .sts              (sts),
      .req_target_value (req_ch.target_value),
      .req_source_value (req_ch.source_value),
      .req_use_source   (req_ch.use_source),
      .req_duration_ms  (req_ch.duration_ms),
      .req_now_ms       (req_ch.now_ms),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_kind         (rsp_ch.kind),
      .rsp_out_channel  (rsp_ch.out_channel),
      .rsp_level        (rsp_ch.level),
      .rsp_event_code   (rsp_ch.event_code),
      .rsp_fade_state   (rsp_ch.fade_state),
      .rsp_last         (rsp_ch.last)
   );

`ifndef NO_ASSERTIONS
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while previous request still in work");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten while still pending");

   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("channel store read and written in the same cycle");

   a_div_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && cmd.div_step))
      else $error("divider loaded and stepped together");
`endif

endmodule
`default_nettype wire

@@ sv/mlf_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlf_datapath
// Channel store, elapsed time, multiplier, serial divider and result register.
// ----------------------------------------------------------------------------
module mlf_datapath #(
   parameter int CHANNELS = mlf_pkg::CHANNELS_DEF,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  mlf_pkg::ctl_cmd_type       cmd,
   input  wire  [CH_W-1:0]            addr,
   output mlf_pkg::dp_status_type     sts,
   input  wire  [15:0]                req_target_value,
   input  wire  [15:0]                req_source_value,
   input  wire                        req_use_source,
   input  wire  [31:0]                req_duration_ms,
   input  wire  [31:0]                req_now_ms,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic                       rsp_kind,
   output logic [3:0]                 rsp_out_channel,
   output logic [15:0]                rsp_level,
   output logic                       rsp_event_code,
   output logic                       rsp_fade_state,
   output logic                       rsp_last
);

   logic [15:0] tgt_ff, src_ff;
   logic        use_ff;
   logic [31:0] dur_ff, now_ff;
   logic [31:0] start_ff, len_ff;
   logic [31:0] elapsed_ff;
   logic        lt_ff;

   mlf_pkg::row_type mem [CHANNELS];
   logic [CHANNELS-1:0] row_valid_ff;
   mlf_pkg::row_type rd_ff;
   mlf_pkg::row_type wr_row;

   logic [47:0] prod_ff;
   logic [31:0] rem_ff;
   logic [15:0] quo_ff;
   logic [3:0]  div_cnt_ff;
   logic [32:0] trial;
   logic        trial_ok;

   logic [15:0] setup_src;
   logic [15:0] level_v;
   logic [31:0] elapsed_in;

   logic        out_valid_ff;
   logic        kind_ff, code_ff, state_ff, last_ff;
   logic [3:0]  chan_ff;
   logic [15:0] level_ff;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         tgt_ff <= req_target_value;
         src_ff <= req_source_value;
         use_ff <= req_use_source;
         dur_ff <= req_duration_ms;
         now_ff <= req_now_ms;
      end
   end

   assign elapsed_in = now_ff - start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= '0;
      end else if (cmd.load_fade) begin
         start_ff <= now_ff;
         len_ff   <= dur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_elapsed) begin
         elapsed_ff <= elapsed_in;
         lt_ff      <= elapsed_in < len_ff;
      end
   end

   // channel store; a row never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.wr_en) begin
         row_valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_row;
      end
      if (cmd.rd_en) begin
         rd_ff <= row_valid_ff[addr] ? mem[addr] : '0;
      end
   end

   assign setup_src = use_ff ? src_ff : rd_ff.cur;
   assign level_v   = rd_ff.neg ? rd_ff.src - quo_ff : rd_ff.src + quo_ff;

   always_comb begin
      wr_row = rd_ff;
      case (cmd.wr_sel)
         mlf_pkg::WR_SETUP: begin
            wr_row.src = setup_src;
            wr_row.tgt = tgt_ff;
            if (tgt_ff > setup_src) begin
               wr_row.mag = tgt_ff - setup_src;
               wr_row.neg = 1'b0;
            end else begin
               wr_row.mag = setup_src - tgt_ff;
               wr_row.neg = 1'b1;
            end
         end
         mlf_pkg::WR_LEVEL:  wr_row.cur = level_v;
         mlf_pkg::WR_TARGET: wr_row.cur = rd_ff.tgt;
         default:            wr_row = rd_ff;
      endcase
   end

   // diff * elapsed, then one quotient bit per step; the high product
   // half is already below the length, so sixteen steps suffice
   assign trial    = {rem_ff, quo_ff[15]};
   assign trial_ok = trial >= {1'b0, len_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= 48'(rd_ff.mag) * 48'(elapsed_ff);
      end
      if (cmd.div_start) begin
         rem_ff     <= prod_ff[47:16];
         quo_ff     <= prod_ff[15:0];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= trial_ok ? 32'(trial - {1'b0, len_ff}) : trial[31:0];
         quo_ff     <= {quo_ff[14:0], trial_ok};
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff  <= cmd.out_kind;
         code_ff  <= cmd.out_code;
         state_ff <= cmd.out_state;
         last_ff  <= cmd.out_last;
         chan_ff  <= (cmd.out_kind == mlf_pkg::KIND_LEVEL) ? 4'(addr) : 4'd0;
         level_ff <= (cmd.out_kind == mlf_pkg::KIND_LEVEL) ? rd_ff.cur : 16'd0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_channel = chan_ff;
   assign rsp_level       = level_ff;
   assign rsp_event_code  = code_ff;
   assign rsp_fade_state  = state_ff;
   assign rsp_last        = last_ff;

   assign sts.lt       = lt_ff;
   assign sts.div_last = div_cnt_ff == 4'd15;
   assign sts.changed  = level_v != rd_ff.cur;
   assign sts.out_free = !out_valid_ff || rsp_ready;

endmodule
`default_nettype wire

@@ sv/mlf_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlf_controller
// Sequencer for setup, fade update, completion and result delivery.
// ----------------------------------------------------------------------------
module mlf_controller #(
   parameter int CHANNELS = mlf_pkg::CHANNELS_DEF,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [1:0]                     req_opcode,
   input  wire  [3:0]                     req_channel,
   input  wire                            csr_write_enable,
   input  wire  [mlf_pkg::ACTIVE_W-1:0]   csr_write_data,
   input  mlf_pkg::dp_status_type         sts,
   output mlf_pkg::ctl_cmd_type           cmd,
   output logic [CH_W-1:0]                addr
);

   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int CMP_W = CNT_W + mlf_pkg::ACTIVE_W;
   localparam int TOT_W = CNT_W + mlf_pkg::RES_W;
   localparam int RES_W = mlf_pkg::RES_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SET_RD, S_SET_WR, S_DECIDE, S_BRANCH,
      S_F_RD, S_F_MUL, S_F_DIV0, S_F_DIV, S_F_WB, S_T_RD, S_T_WR,
      S_E_BEGIN, S_E_STOP, S_E_LRD, S_E_LOUT, S_E_FIN, S_E_ST
   } state_type;

   state_type state_ff, state_in;
   mlf_pkg::opcode_type op_ff, op_in;
   logic [3:0] ch_ff, ch_in;
   logic run_ff, run_in, fin_ff, fin_in, mode_ff, mode_in;
   logic [mlf_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic ev_stop_ff, ev_stop_in, fin_evt_ff, fin_evt_in, fin_state_ff, fin_state_in;
   logic st_evt_ff, st_evt_in, st_state_ff, st_state_in, lev_ff, lev_in;
   logic [CH_W-1:0]  idx_ff, idx_in;
   logic [RES_W-1:0] k_ff, k_in, cap_ff, cap_in;

   logic [CNT_W-1:0] n_used;
   logic [TOT_W-1:0] total;
   logic             stop_cond, last_idx, done, ch_ok;

   assign n_used = (CMP_W'(active_ff) > CMP_W'(CHANNELS)) ? CNT_W'(CHANNELS)
                                                          : CNT_W'(active_ff);
   assign last_idx  = (CNT_W'(idx_ff) + CNT_W'(1)) == n_used;
   assign stop_cond = !fin_ff || run_ff;
   assign ch_ok     = CMP_W'(ch_ff) < CMP_W'(CHANNELS);
   assign done      = k_ff == cap_ff;
   assign total     = TOT_W'(ev_stop_ff) + TOT_W'(fin_evt_ff) + TOT_W'(st_evt_ff)
                    + (lev_ff ? TOT_W'(n_used) : TOT_W'(0));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      run_in       = run_ff;
      fin_in       = fin_ff;
      mode_in      = mode_ff;
      active_in    = csr_write_enable ? csr_write_data : active_ff;
      ev_stop_in   = ev_stop_ff;
      fin_evt_in   = fin_evt_ff;
      fin_state_in = fin_state_ff;
      st_evt_in    = st_evt_ff;
      st_state_in  = st_state_ff;
      lev_in       = lev_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      cap_in       = cap_ff;
      cmd          = '0;
      cmd.wr_sel   = mlf_pkg::WR_SETUP;
      addr         = idx_ff;
      req_ready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               op_in    = mlf_pkg::opcode_type'(req_opcode);
               ch_in    = req_channel;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ev_stop_in = 1'b0;
            fin_evt_in = 1'b0;
            st_evt_in  = 1'b0;
            lev_in     = 1'b0;
            case (op_ff)
               mlf_pkg::OP_SETUP: state_in = ch_ok ? S_SET_RD : S_IDLE;
               mlf_pkg::OP_START: begin
                  ev_stop_in    = stop_cond && mode_ff;
                  mode_in       = stop_cond ? mlf_pkg::MODE_REST : mode_ff;
                  run_in        = 1'b1;
                  fin_in        = 1'b0;
                  cmd.load_fade = 1'b1;
                  state_in      = S_DECIDE;
               end
               mlf_pkg::OP_TICK: begin
                  if (run_ff) begin
                     state_in = S_DECIDE;
                  end else begin
                     st_evt_in   = mode_ff;
                     st_state_in = mlf_pkg::MODE_REST;
                     mode_in     = mlf_pkg::MODE_REST;
                     state_in    = S_E_BEGIN;
                  end
               end
               default: begin
                  if (stop_cond) begin
                     ev_stop_in = mode_ff;
                     mode_in    = mlf_pkg::MODE_REST;
                     run_in     = 1'b0;
                     fin_in     = 1'b1;
                     state_in   = S_E_BEGIN;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_SET_RD: begin
            addr       = CH_W'(ch_ff);
            cmd.rd_en  = 1'b1;
            state_in   = S_SET_WR;
         end
         S_SET_WR: begin
            addr       = CH_W'(ch_ff);
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = mlf_pkg::WR_SETUP;
            state_in   = S_IDLE;
         end
         S_DECIDE: begin
            cmd.calc_elapsed = 1'b1;
            state_in         = S_BRANCH;
         end
         S_BRANCH: begin
            idx_in = '0;
            if (sts.lt) begin
               st_evt_in   = !mode_ff;
               st_state_in = mlf_pkg::MODE_FADE;
               mode_in     = mlf_pkg::MODE_FADE;
               state_in    = (n_used == '0) ? S_E_BEGIN : S_F_RD;
            end else begin
               run_in       = 1'b0;
               fin_in       = 1'b1;
               fin_evt_in   = 1'b1;
               fin_state_in = mode_ff;
               lev_in       = n_used != '0;
               st_evt_in    = mode_ff;
               st_state_in  = mlf_pkg::MODE_REST;
               mode_in      = mlf_pkg::MODE_REST;
               state_in     = (n_used == '0) ? S_E_BEGIN : S_T_RD;
            end
         end
         S_F_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_F_MUL;
         end
         S_F_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_F_DIV0;
         end
         S_F_DIV0: begin
            cmd.div_start = 1'b1;
            state_in      = S_F_DIV;
         end
         S_F_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_F_WB;
            end
         end
         S_F_WB: begin
            if (sts.changed) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mlf_pkg::WR_LEVEL;
               lev_in     = 1'b1;
            end
            if (last_idx) begin
               state_in = S_E_BEGIN;
            end else begin
               idx_in   = idx_ff + CH_W'(1);
               state_in = S_F_RD;
            end
         end
         S_T_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_T_WR;
         end
         S_T_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = mlf_pkg::WR_TARGET;
            if (last_idx) begin
               state_in = S_E_BEGIN;
            end else begin
               idx_in   = idx_ff + CH_W'(1);
               state_in = S_T_RD;
            end
         end
         S_E_BEGIN: begin
            cap_in   = (total > TOT_W'(mlf_pkg::MAX_RESULTS)) ?
                       RES_W'(mlf_pkg::MAX_RESULTS) : RES_W'(total);
            k_in     = '0;
            idx_in   = '0;
            state_in = S_E_STOP;
         end
         S_E_STOP: begin
            if (done) begin
               state_in = S_IDLE;
            end else if (!ev_stop_ff) begin
               state_in = S_E_LRD;
            end else if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = mlf_pkg::KIND_EVENT;
               cmd.out_code  = mlf_pkg::EVT_CHANGED;
               cmd.out_state = mlf_pkg::MODE_REST;
               cmd.out_last  = RES_W'(k_ff + RES_W'(1)) == cap_ff;
               k_in          = k_ff + RES_W'(1);
               state_in      = S_E_LRD;
            end
         end
         S_E_LRD: begin
            if (done) begin
               state_in = S_IDLE;
            end else if (!lev_ff) begin
               state_in = S_E_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_E_LOUT;
            end
         end
         S_E_LOUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = mlf_pkg::KIND_LEVEL;
               cmd.out_last = RES_W'(k_ff + RES_W'(1)) == cap_ff;
               k_in         = k_ff + RES_W'(1);
               if (last_idx) begin
                  state_in = S_E_FIN;
               end else begin
                  idx_in   = idx_ff + CH_W'(1);
                  state_in = S_E_LRD;
               end
            end
         end
         S_E_FIN: begin
            if (done) begin
               state_in = S_IDLE;
            end else if (!fin_evt_ff) begin
               state_in = S_E_ST;
            end else if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = mlf_pkg::KIND_EVENT;
               cmd.out_code  = mlf_pkg::EVT_FINISHED;
               cmd.out_state = fin_state_ff;
               cmd.out_last  = RES_W'(k_ff + RES_W'(1)) == cap_ff;
               k_in          = k_ff + RES_W'(1);
               state_in      = S_E_ST;
            end
         end
         S_E_ST: begin
            if (done || !st_evt_ff) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = mlf_pkg::KIND_EVENT;
               cmd.out_code  = mlf_pkg::EVT_CHANGED;
               cmd.out_state = st_state_ff;
               cmd.out_last  = RES_W'(k_ff + RES_W'(1)) == cap_ff;
               k_in          = k_ff + RES_W'(1);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         run_ff    <= 1'b0;
         fin_ff    <= 1'b1;
         mode_ff   <= mlf_pkg::MODE_REST;
         active_ff <= mlf_pkg::ACTIVE_RESET;
         k_ff      <= '0;
         cap_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         run_ff    <= run_in;
         fin_ff    <= fin_in;
         mode_ff   <= mode_in;
         active_ff <= active_in;
         k_ff      <= k_in;
         cap_ff    <= cap_in;
      end
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      ev_stop_ff   <= ev_stop_in;
      fin_evt_ff   <= fin_evt_in;
      fin_state_ff <= fin_state_in;
      st_evt_ff    <= st_evt_in;
      st_state_ff  <= st_state_in;
      lev_ff       <= lev_in;
      idx_ff       <= idx_in;
   end

endmodule
`default_nettype wire
